>>> hw/rtl/dbfm_pkg.sv
// Shared types and constants for the dual beacon flash frequency meter.
// Used by every module of the block; depends on nothing.
package dbfm_pkg;

  localparam int THRESH_BITS     = 10;
  localparam int RATE_BITS       = 8;
  localparam int LEVEL_OUT_BITS  = 10;
  localparam int TALLY_BITS      = 4;

  localparam int WINDOW_TICKS_DEF = 4;
  localparam int SAMPLE_BITS_DEF  = 10;
  localparam int COUNT_BITS_DEF   = 16;

  localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(100);
  localparam logic [RATE_BITS-1:0]   RATE_MAX     = '1;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  // Per-channel control: take a new reading, or clear the flash count.
  typedef struct packed {
    logic sample;
    logic clear;
  } chan_ctl_t;

endpackage

>>> hw/rtl/dbfm_flash_chan.sv
// One light channel: latest reading, threshold crossing detect and
// saturating flash counter. Depends on dbfm_pkg.
module dbfm_flash_chan
  import dbfm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  chan_ctl_t              ctl,
  input  logic [SAMPLE_BITS-1:0] level,
  input  logic [THRESH_BITS-1:0] threshold,
  output logic [SAMPLE_BITS-1:0] last_level,
  output logic [COUNT_BITS-1:0]  flashes
);

  localparam int CMP_BITS = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;

  logic [SAMPLE_BITS-1:0] last_r, last_nxt;
  logic [COUNT_BITS-1:0]  count_r, count_nxt;
  logic [CMP_BITS-1:0]    cur_w, prev_w, th_w;
  logic                   rise;

  assign cur_w  = CMP_BITS'(level);
  assign prev_w = CMP_BITS'(last_r);
  assign th_w   = CMP_BITS'(threshold);
  // A reading exactly at the threshold counts as below it for the next rise.
  assign rise   = (cur_w > th_w) && (prev_w <= th_w);

  always_comb begin
    last_nxt  = last_r;
    count_nxt = count_r;
    if (ctl.clear) begin
      count_nxt = '0;
    end else if (ctl.sample) begin
      last_nxt = level;
      if (rise && (count_r != '1)) begin
        count_nxt = count_r + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= '0;
      count_r <= '0;
    end else begin
      last_r  <= last_nxt;
      count_r <= count_nxt;
    end
  end

  assign last_level = last_r;
  assign flashes    = count_r;

endmodule

>>> hw/rtl/dbfm_rate_div.sv
// Flash count to rate: divide by the window length, saturate at the rate maximum.
// Constant divide by reciprocal multiply and one correction. Depends on dbfm_pkg.
module dbfm_rate_div
  import dbfm_pkg::*;
#(
  parameter int COUNT_BITS   = COUNT_BITS_DEF,
  parameter int WINDOW_TICKS = WINDOW_TICKS_DEF
) (
  input  logic [COUNT_BITS-1:0] count,
  output logic [RATE_BITS-1:0]  rate
);

  // Any count that does not saturate fits in X_BITS.
  localparam int X_BITS    = RATE_BITS + TALLY_BITS;
  localparam int WIDE_BITS = (COUNT_BITS > X_BITS) ? COUNT_BITS : X_BITS;
  localparam int SAT_LIMIT = (1 << RATE_BITS) * WINDOW_TICKS;
  localparam int SHIFT     = X_BITS + TALLY_BITS;
  localparam int M_BITS    = SHIFT + 1;
  localparam int RECIP     = (1 << SHIFT) / WINDOW_TICKS;
  localparam int P_BITS    = X_BITS + M_BITS;

  logic [WIDE_BITS-1:0] wide;
  logic                 sat;
  logic [X_BITS-1:0]    x;
  logic [P_BITS-1:0]    prod;
  logic [RATE_BITS-1:0] q_est;
  logic [X_BITS-1:0]    q_times_w;
  logic [X_BITS-1:0]    rem;

  assign wide = WIDE_BITS'(count);
  assign sat  = wide >= WIDE_BITS'(SAT_LIMIT);
  assign x    = wide[X_BITS-1:0];

  // The estimate is the true quotient or one below it.
  assign prod      = P_BITS'(x) * P_BITS'(RECIP);
  assign q_est     = prod[SHIFT +: RATE_BITS];
  assign q_times_w = X_BITS'(q_est) * X_BITS'(WINDOW_TICKS);
  assign rem       = x - q_times_w;

  always_comb begin
    if (sat) begin
      rate = RATE_MAX;
    end else if (rem >= X_BITS'(WINDOW_TICKS)) begin
      rate = q_est + RATE_BITS'(1);
    end else begin
      rate = q_est;
    end
  end

endmodule

>>> hw/rtl/dual_beacon_flash_frequency_meter.sv
// Top level of the dual beacon flash frequency meter: input stage, tick window,
// result register. Depends on dbfm_pkg, dbfm_flash_chan and dbfm_rate_div.
//
//   channel | direction | handshake          | beat
//   in_     | input     | in_valid/in_stall  | opcode, left and right reading
//   out_    | output    | out_valid/out_stall| flash rate, winning reading
//   cfg_    | input     | cfg_valid/cfg_ready| light threshold
//
// One item is accepted per cycle while in_stall is low. An item is held in the input stage,
// where it updates the channel state; a window-closing tick loads the result
// register there as it leaves the stage, which sets the registered out_valid.
// in_stall rises only while a window-closing tick waits for a full, stalled
// result register; samples and other ticks keep flowing behind a held result.
// rst_n is synchronous: it clears readings, counts, tick tally and sets the
// threshold to 100. cfg_ready is always high.
module dual_beacon_flash_frequency_meter
  import dbfm_pkg::*;
#(
  parameter int WINDOW_TICKS = WINDOW_TICKS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_opcode,
  input  logic [SAMPLE_BITS-1:0]    in_left_level,
  input  logic [SAMPLE_BITS-1:0]    in_right_level,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [RATE_BITS-1:0]      out_flash_rate,
  output logic [LEVEL_OUT_BITS-1:0] out_winning_level,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [THRESH_BITS-1:0]    cfg_light_threshold
);

  logic                   s_valid_r, s_valid_nxt;
  op_t                    s_op_r;
  logic [SAMPLE_BITS-1:0] s_left_r, s_right_r;
  logic [TALLY_BITS-1:0]  tally_r, tally_nxt, tally_inc;
  logic [THRESH_BITS-1:0] thresh_r, thresh_nxt;
  logic                   o_valid_r, o_valid_nxt;
  logic [RATE_BITS-1:0]   o_rate_r;
  logic [LEVEL_OUT_BITS-1:0] o_level_r;

  logic                   in_take, closes, advance, load_out;
  chan_ctl_t              ctl;
  logic [SAMPLE_BITS-1:0] last_left, last_right;
  logic [COUNT_BITS-1:0]  left_flashes, right_flashes;
  logic [RATE_BITS-1:0]   left_rate, right_rate;

  assign tally_inc = tally_r + TALLY_BITS'(1);
  assign closes    = s_valid_r && (s_op_r == OP_TICK) &&
                     (tally_inc == TALLY_BITS'(WINDOW_TICKS));
  assign advance   = s_valid_r && !(closes && o_valid_r && out_stall);
  assign load_out  = advance && closes;
  assign in_stall  = s_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;

  assign ctl.sample = advance && (s_op_r == OP_SAMPLE);
  assign ctl.clear  = load_out;

  dbfm_flash_chan #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) u_left (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .level(s_left_r), .threshold(thresh_r),
    .last_level(last_left), .flashes(left_flashes)
  );

  dbfm_flash_chan #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) u_right (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .level(s_right_r), .threshold(thresh_r),
    .last_level(last_right), .flashes(right_flashes)
  );

  dbfm_rate_div #(.COUNT_BITS(COUNT_BITS), .WINDOW_TICKS(WINDOW_TICKS)) u_left_rate (
    .count(left_flashes), .rate(left_rate)
  );

  dbfm_rate_div #(.COUNT_BITS(COUNT_BITS), .WINDOW_TICKS(WINDOW_TICKS)) u_right_rate (
    .count(right_flashes), .rate(right_rate)
  );

  always_comb begin
    s_valid_nxt = s_valid_r;
    if (in_take) begin
      s_valid_nxt = 1'b1;
    end else if (advance) begin
      s_valid_nxt = 1'b0;
    end

    tally_nxt = tally_r;
    if (load_out) begin
      tally_nxt = '0;
    end else if (advance && (s_op_r == OP_TICK)) begin
      tally_nxt = tally_inc;
    end

    o_valid_nxt = o_valid_r;
    if (load_out) begin
      o_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      o_valid_nxt = 1'b0;
    end

    thresh_nxt = cfg_valid ? cfg_light_threshold : thresh_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      tally_r   <= '0;
      o_valid_r <= 1'b0;
      thresh_r  <= THRESH_RESET;
    end else begin
      s_valid_r <= s_valid_nxt;
      tally_r   <= tally_nxt;
      o_valid_r <= o_valid_nxt;
      thresh_r  <= thresh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s_op_r    <= op_t'(in_opcode);
      s_left_r  <= in_left_level;
      s_right_r <= in_right_level;
    end
    // Ties go to the right channel.
    if (load_out) begin
      if (left_rate > right_rate) begin
        o_rate_r  <= left_rate;
        o_level_r <= LEVEL_OUT_BITS'(last_left);
      end else begin
        o_rate_r  <= right_rate;
        o_level_r <= LEVEL_OUT_BITS'(last_right);
      end
    end
  end

  assign cfg_ready         = 1'b1;
  assign out_valid         = o_valid_r;
  assign out_flash_rate    = o_rate_r;
  assign out_winning_level = o_level_r;

  a_clear_after_close: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (left_flashes == '0) && (right_flashes == '0) && (tally_r == '0))
    else $error("flash counts not cleared after a window closed");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid)
    else $error("closed window did not present a result");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_stall && o_valid_r && closes))
    else $error("input stalled without a blocked result");

endmodule

>>> tb/sv/dual_beacon_flash_frequency_meter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the dual beacon flash frequency meter: random and directed
// sample and tick beats, a window-rate predictor in a small scoreboard class.
// Depends on dbfm_pkg and dual_beacon_flash_frequency_meter.
module dual_beacon_flash_frequency_meter_tb;
  import dbfm_pkg::*;

  localparam int WINDOW      = WINDOW_TICKS_DEF;
  localparam int LVL_BITS    = SAMPLE_BITS_DEF;
  localparam int CNT_BITS    = COUNT_BITS_DEF;
  localparam int LEVEL_MAX   = (1 << LVL_BITS) - 1;
  localparam int FLASH_RUN   = 50;
  localparam int RIGHT_RUN   = 30;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE_CYC  = 4;

  typedef struct packed {
    logic [RATE_BITS-1:0]      rate;
    logic [LEVEL_OUT_BITS-1:0] level;
  } window_report_t;

  class flash_window_board;
    logic [THRESH_BITS-1:0] threshold;
    logic [LVL_BITS-1:0]    prev_left;
    logic [LVL_BITS-1:0]    prev_right;
    logic [CNT_BITS-1:0]    left_count;
    logic [CNT_BITS-1:0]    right_count;
    logic [TALLY_BITS-1:0]  ticks;
    window_report_t         awaited[$];
    int                     mismatches;

    function new();
      threshold   = THRESH_RESET;
      prev_left   = '0;
      prev_right  = '0;
      left_count  = '0;
      right_count = '0;
      ticks       = '0;
      mismatches  = 0;
    endfunction

    function logic [CNT_BITS-1:0] bumped(logic [CNT_BITS-1:0] c);
      return (c == '1) ? c : c + 1'b1;
    endfunction

    function logic [RATE_BITS-1:0] rate_of(logic [CNT_BITS-1:0] c);
      int unsigned q;
      q = c / WINDOW;
      return (q > RATE_MAX) ? RATE_MAX : RATE_BITS'(q);
    endfunction

    function void note_beat(op_t op, logic [LVL_BITS-1:0] l, logic [LVL_BITS-1:0] r);
      window_report_t rep;
      logic [RATE_BITS-1:0] lr;
      logic [RATE_BITS-1:0] rr;
      if (op == OP_SAMPLE) begin
        if (l > threshold && prev_left <= threshold) left_count = bumped(left_count);
        if (r > threshold && prev_right <= threshold) right_count = bumped(right_count);
        prev_left  = l;
        prev_right = r;
      end else begin
        ticks = ticks + 1'b1;
        if (ticks == TALLY_BITS'(WINDOW)) begin
          lr = rate_of(left_count);
          rr = rate_of(right_count);
          // The right channel wins a tie.
          if (lr > rr) begin
            rep.rate  = lr;
            rep.level = prev_left;
          end else begin
            rep.rate  = rr;
            rep.level = prev_right;
          end
          awaited.push_back(rep);
          left_count  = '0;
          right_count = '0;
          ticks       = '0;
        end
      end
    endfunction

    function void report(string what);
      if (mismatches < 40) $display("mismatch: %s", what);
      mismatches++;
    endfunction

    function void check_report(logic [RATE_BITS-1:0] rate, logic [LEVEL_OUT_BITS-1:0] level);
      window_report_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result beat rate %0d level %0d", rate, level));
        return;
      end
      want = awaited.pop_front();
      if (rate !== want.rate)
        report($sformatf("flash_rate %0d, predicted %0d", rate, want.rate));
      if (level !== want.level)
        report($sformatf("winning_level %0d, predicted %0d", level, want.level));
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic                      in_opcode;
  logic [LVL_BITS-1:0]       in_left_level;
  logic [LVL_BITS-1:0]       in_right_level;
  logic                      out_valid;
  logic                      out_stall;
  logic [RATE_BITS-1:0]      out_flash_rate;
  logic [LEVEL_OUT_BITS-1:0] out_winning_level;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [THRESH_BITS-1:0]    cfg_light_threshold;

  logic idle_on;
  logic hold_req;

  flash_window_board meter = new();

  dual_beacon_flash_frequency_meter uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_left_level       (in_left_level),
    .in_right_level      (in_right_level),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_flash_rate      (out_flash_rate),
    .out_winning_level   (out_winning_level),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_light_threshold (cfg_light_threshold)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) meter.check_report(out_flash_rate, out_winning_level);
  end

  // Receiver side: random stall bursts, or one long hold when asked for.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
        hold_req  = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Levels cluster around the threshold so that crossings are frequent.
  function automatic logic [LVL_BITS-1:0] pick_level(int thr);
    int v;
    case ($urandom_range(0, 5))
      0, 1:    v = $urandom_range(0, LEVEL_MAX);
      2:       v = thr + $urandom_range(0, 3) - 1;
      3:       v = 0;
      4:       v = LEVEL_MAX;
      default: v = $urandom_range(0, thr);
    endcase
    if (v < 0) v = 0;
    if (v > LEVEL_MAX) v = LEVEL_MAX;
    return LVL_BITS'(v);
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(op_t op, logic [LVL_BITS-1:0] l, logic [LVL_BITS-1:0] r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_opcode      = op;
    in_left_level  = l;
    in_right_level = r;
    do @(posedge clk); while (in_stall);
    meter.note_beat(op, l, r);
    @(negedge clk);
  endtask

  task automatic random_run(int n);
    op_t op;
    repeat (n) begin
      op = ($urandom_range(0, 4) == 0) ? OP_TICK : OP_SAMPLE;
      send_beat(op, pick_level(meter.threshold), pick_level(meter.threshold));
    end
  endtask

  // A sample still in the input stage sees the threshold, so wait it out too.
  task automatic settle();
    in_valid = 1'b0;
    while (meter.awaited.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_threshold(logic [THRESH_BITS-1:0] v);
    settle();
    cfg_valid           = 1'b1;
    cfg_light_threshold = v;
    do @(posedge clk); while (!cfg_ready);
    meter.threshold = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_opcode           = OP_SAMPLE;
    in_left_level       = '0;
    in_right_level      = '0;
    cfg_valid           = 1'b0;
    cfg_light_threshold = '0;
    idle_on             = 1'b0;
    hold_req            = 1'b0;
    repeat (3) @(negedge clk);
    rst_n   = 1'b1;
    idle_on = 1'b1;

    // A window before any sample reports zero readings; tick levels are ignored.
    repeat (WINDOW) send_beat(OP_TICK, LVL_BITS'(LEVEL_MAX), LVL_BITS'(LEVEL_MAX));
    // Extremes, and a reading exactly at the threshold followed by a rise.
    send_beat(OP_SAMPLE, 0, 0);
    send_beat(OP_SAMPLE, LVL_BITS'(LEVEL_MAX), LVL_BITS'(LEVEL_MAX));
    send_beat(OP_SAMPLE, 100, 100);
    send_beat(OP_SAMPLE, 101, 100);
    send_beat(OP_SAMPLE, 100, 101);
    send_beat(OP_SAMPLE, 0, LVL_BITS'(LEVEL_MAX));
    repeat (WINDOW) send_beat(OP_TICK, 0, 0);
    // The left channel wins with one flash per tick.
    repeat (WINDOW) begin
      send_beat(OP_SAMPLE, 0, 0);
      send_beat(OP_SAMPLE, 500, 5);
    end
    repeat (WINDOW) send_beat(OP_TICK, 0, 0);

    random_run(300);
    write_threshold('0);
    random_run(300);
    write_threshold('1);
    random_run(300);

    // Hold the result side while ticks keep coming, so the input backs up.
    settle();
    idle_on  = 1'b0;
    hold_req = 1'b1;
    repeat (10 * WINDOW) send_beat(OP_TICK, pick_level(0), pick_level(0));
    idle_on = 1'b1;

    write_threshold(THRESH_BITS'($urandom_range(1, LEVEL_MAX - 1)));
    random_run(300);
    write_threshold(THRESH_RESET);
    random_run(300);

    idle_on = 1'b0;
    random_run(100);
    // A long run of back to back flashes, the left channel ahead of the right one.
    for (int i = 0; i < FLASH_RUN; i++) begin
      send_beat(OP_SAMPLE, 0, 0);
      send_beat(OP_SAMPLE, LVL_BITS'(LEVEL_MAX), (i < RIGHT_RUN) ? LVL_BITS'(LEVEL_MAX) : '0);
    end
    repeat (2 * WINDOW) send_beat(OP_TICK, 0, 0);

    in_valid = 1'b0;
    while (meter.awaited.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (meter.awaited.size() != 0) meter.report("results still awaited at the end");
    if (meter.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
